[hw/rtl/ssl_pkg.sv]
package ssl_pkg;

	// Number of servo channels in use and the number of result slots.
	localparam int unsigned NUM_CHANNELS = 3;
	localparam int unsigned NCH_STORE    = 3;

	// Configuration register reset values.
	localparam logic [15:0] RST_MIN_PULSE    = 16'd500;
	localparam logic [15:0] RST_MAX_PULSE    = 16'd2500;
	localparam logic [15:0] RST_MID_PULSE    = 16'd1500;
	localparam logic [15:0] RST_MAX_STEP     = 16'd200;
	localparam logic [15:0] RST_DEFAULT_STEP = 16'd20;

	// Register file addressing: register i sits at byte address 4*i.
	localparam int unsigned PADDR_W = 5;

	localparam logic [2:0] REG_MIN_PULSE    = 3'd0;
	localparam logic [2:0] REG_MAX_PULSE    = 3'd1;
	localparam logic [2:0] REG_MID_PULSE    = 3'd2;
	localparam logic [2:0] REG_MAX_STEP     = 3'd3;
	localparam logic [2:0] REG_DEFAULT_STEP = 3'd4;

	// Request kinds.
	localparam logic REQ_SET  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Target codes used when a value lies outside the allowed range.
	localparam logic [15:0] CODE_MIN = 16'd0;
	localparam logic [15:0] CODE_MAX = 16'd1;
	localparam logic [15:0] CODE_MID = 16'd2;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  channel;
		logic [15:0] target_value;
		logic [15:0] speed;
	} req_t;

	typedef struct packed {
		logic [15:0] reply_value;
		logic [15:0] width_ch0;
		logic [15:0] width_ch1;
		logic [15:0] width_ch2;
		logic        at_pos_ch0;
		logic        at_pos_ch1;
		logic        at_pos_ch2;
	} rsp_t;

	// Live configuration seen by every channel.
	typedef struct packed {
		logic [15:0] min_pulse;
		logic [15:0] max_pulse;
		logic [15:0] mid_pulse;
		logic [15:0] max_step;
	} cfg_t;

endpackage

[hw/rtl/ssl_chan.sv]
module ssl_chan (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          sel,
	input  ssl_pkg::req_t req,
	input  ssl_pkg::cfg_t cfg,
	output logic [15:0]   width,
	output logic          at_pos
);
	import ssl_pkg::*;

	logic [15:0] width_q;
	logic [15:0] target_q;
	logic [15:0] step_q;
	logic        at_pos_q;

	logic        below;
	logic [15:0] span;
	logic [15:0] move;
	logic [15:0] width_tick;
	logic        in_range;
	logic        taken;
	logic [15:0] target_new;

	// Slew: move toward the target by at most the channel step.
	always_comb begin
		below      = width_q < target_q;
		span       = below ? (target_q - width_q) : (width_q - target_q);
		move       = (span > step_q) ? step_q : span;
		width_tick = below ? (width_q + move) : (width_q - move);
	end

	// Target selection: an in-range value wins over the codes.
	always_comb begin
		in_range   = (req.target_value >= cfg.min_pulse) &&
			(req.target_value <= cfg.max_pulse);
		taken      = 1'b1;
		target_new = req.target_value;
		if (!in_range) begin
			case (req.target_value)
				CODE_MIN: target_new = cfg.min_pulse;
				CODE_MAX: target_new = cfg.max_pulse;
				CODE_MID: target_new = cfg.mid_pulse;
				default: taken = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			target_q <= RST_MID_PULSE;
			step_q   <= RST_DEFAULT_STEP;
			at_pos_q <= 1'b0;
		end else if (en) begin
			if (req.req_type == REQ_TICK) begin
				if (width_q == target_q) begin
					at_pos_q <= 1'b1;
				end else begin
					width_q <= width_tick;
				end
			end else if (sel) begin
				if (req.speed != '0) begin
					step_q <= (req.speed > cfg.max_step) ? cfg.max_step : req.speed;
				end
				if (taken) begin
					target_q <= target_new;
					at_pos_q <= 1'b0;
				end
			end
		end
	end

	assign width  = width_q;
	assign at_pos = at_pos_q;

	// A tick that finds the width on target raises the flag and holds the width.
	assert property (@(posedge clk) disable iff (!arst_n)
		en && req.req_type == REQ_TICK && width_q == target_q
		|=> at_pos_q && $stable(width_q))
		else $error("ssl_chan: on-target tick did not settle");

	// The width never moves except on a tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(en && req.req_type == REQ_TICK) |=> $stable(width_q))
		else $error("ssl_chan: width moved without a tick");

endmodule

[hw/rtl/servo_slew_limiter_3ch.sv]
// A request accepted into the request register is applied to the channel state, and its
// result is loaded into the result register, once the result slot is empty or being taken.
// Throughput: one request per cycle while results are taken; the channel update is a single
// compare, subtract and clamp between the request register and the channel state registers.
// Reset (arst_n low, asynchronous) empties the pipeline, returns the configuration
// registers to their defaults and sets every channel to width 0, the default mid
// target, the default step and a cleared at-position flag.
module servo_slew_limiter_3ch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssl_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  ssl_pkg::req_t                 req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output ssl_pkg::rsp_t                 rsp_data
);
	import ssl_pkg::*;

	// Configuration registers. The default step and mid value only matter
	// through reset; the live mid value is still used for the mid code.
	logic [15:0] min_pulse_q;
	logic [15:0] max_pulse_q;
	logic [15:0] mid_pulse_q;
	logic [15:0] max_step_q;
	logic [15:0] default_step_q;
	cfg_t        cfg;
	logic        cfg_wr;
	logic [2:0]  reg_idx;

	// Request register and result register.
	req_t        item_s1;
	logic        valid_s1;
	logic        adv;
	logic        accept;
	logic [15:0] reply_s2;
	logic        rsp_valid_q;

	// Channel state as seen at the ports; slots beyond the channel count read zero.
	logic [15:0] widths [NCH_STORE];
	logic        flags  [NCH_STORE];
	logic [15:0] reply_next;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q    <= RST_MIN_PULSE;
			max_pulse_q    <= RST_MAX_PULSE;
			mid_pulse_q    <= RST_MID_PULSE;
			max_step_q     <= RST_MAX_STEP;
			default_step_q <= RST_DEFAULT_STEP;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MIN_PULSE:    min_pulse_q    <= pwdata[15:0];
				REG_MAX_PULSE:    max_pulse_q    <= pwdata[15:0];
				REG_MID_PULSE:    mid_pulse_q    <= pwdata[15:0];
				REG_MAX_STEP:     max_step_q     <= pwdata[15:0];
				REG_DEFAULT_STEP: default_step_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register readback; addresses past the last register read as zero.
	always_comb begin
		unique case (reg_idx)
			REG_MIN_PULSE:    prdata = {16'd0, min_pulse_q};
			REG_MAX_PULSE:    prdata = {16'd0, max_pulse_q};
			REG_MID_PULSE:    prdata = {16'd0, mid_pulse_q};
			REG_MAX_STEP:     prdata = {16'd0, max_step_q};
			REG_DEFAULT_STEP: prdata = {16'd0, default_step_q};
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		cfg.min_pulse = min_pulse_q;
		cfg.max_pulse = max_pulse_q;
		cfg.mid_pulse = mid_pulse_q;
		cfg.max_step  = max_step_q;
	end

	// The request in the first stage is applied to the channel state at the
	// same edge that loads the result register, so the state registers always
	// match the result on offer. The stage moves on whenever the result slot
	// is empty or being taken, which lets a new request enter every cycle.
	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req_data;
		end
	end

	// One slew unit per channel in use.
	for (genvar c = 0; c < NCH_STORE; c++) begin : g_chan
		if (c < NUM_CHANNELS) begin : g_used
			ssl_chan u_chan (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.sel    (item_s1.channel == 2'(c)),
				.req    (item_s1),
				.cfg    (cfg),
				.width  (widths[c]),
				.at_pos (flags[c])
			);
		end else begin : g_unused
			assign widths[c] = '0;
			assign flags[c]  = 1'b0;
		end
	end

	// A set request replies with the addressed channel's width; a tick or a
	// channel that does not exist replies zero. Unused slots already read zero.
	always_comb begin
		reply_next = '0;
		if (item_s1.req_type == REQ_SET) begin
			for (int i = 0; i < NCH_STORE; i++) begin
				if (item_s1.channel == 2'(i)) begin
					reply_next = widths[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			reply_s2 <= reply_next;
		end
	end

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		rsp_data.reply_value = reply_s2;
		rsp_data.width_ch0   = widths[0];
		rsp_data.width_ch1   = widths[1];
		rsp_data.width_ch2   = widths[2];
		rsp_data.at_pos_ch0  = flags[0];
		rsp_data.at_pos_ch1  = flags[1];
		rsp_data.at_pos_ch2  = flags[2];
	end

	// A tick always replies zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.req_type == REQ_TICK |=> reply_s2 == '0)
		else $error("ssl: tick produced a nonzero reply");

	// A set request never moves any width.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.req_type == REQ_SET
		|=> $stable(widths[0]) && $stable(widths[1]) && $stable(widths[2]))
		else $error("ssl: set request moved a width");

	// Channel state only changes when a result is loaded, so a held result
	// keeps showing the state it was produced with.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> $stable(widths[0]) && $stable(flags[0]))
		else $error("ssl: channel state changed under a held result");

	// The request stage only stalls when it holds a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid_q)
		else $error("ssl: stall without a blocked request");

endmodule

[test/servo_slew_limiter_3ch_tb.sv]
`timescale 1ns / 1ps

module servo_slew_limiter_3ch_tb;
	import ssl_pkg::*;

	// Random requests per configuration phase; seven phases give roughly
	// 1550 requests together with the directed table.
	localparam int unsigned PHASE_ITEMS  = 220;
	localparam int unsigned PHASES       = 7;
	// Long receiver hold-off used once to back the pipeline up into the input.
	localparam int unsigned HOLD_CYCLES  = 300;
	// The longest quiet stretch of a correct run is the hold-off plus a long
	// sender gap, so this leaves ample room while still catching a hang.
	localparam int unsigned IDLE_LIMIT   = 2000;
	// The block holds a taken request in its request register before it offers the result.
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam logic [1:0]  BAD_CHANNEL  = 2'(NUM_CHANNELS);

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                req_valid;
	logic                req_stall;
	req_t                req_data;
	logic                rsp_valid;
	logic                rsp_stall;
	rsp_t                rsp_data;

	servo_slew_limiter_3ch u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the configuration registers, updated on every write.
	logic [15:0] lim_min, lim_max, lim_mid, lim_step, dflt_step;

	// Shadow copy of the per-channel servo state.
	logic [15:0] pulse_now  [NCH_STORE];
	logic [15:0] pulse_goal [NCH_STORE];
	logic [15:0] pulse_step [NCH_STORE];
	logic        in_place   [NCH_STORE];

	// Status words still owed by the block, oldest first.
	rsp_t        pending_status [$];

	// Directed table: one request per row, with a hand-typed status word where
	// the answer is obvious and the predictor's answer elsewhere.
	req_t        plan_req   [$];
	bit          plan_typed [$];
	rsp_t        plan_want  [$];

	int unsigned mismatch_cnt;
	int unsigned quiet_cycles;
	int unsigned tick_pct;
	bit          idle_on;
	bit          hold_req;
	rsp_t        want_status;

	// Puts the shadow state where reset leaves the block.
	function automatic void reset_shadow();
		int unsigned c;
		lim_min   = RST_MIN_PULSE;
		lim_max   = RST_MAX_PULSE;
		lim_mid   = RST_MID_PULSE;
		lim_step  = RST_MAX_STEP;
		dflt_step = RST_DEFAULT_STEP;
		for (c = 0; c < NCH_STORE; c++) begin
			pulse_now[c]  = 16'd0;
			pulse_goal[c] = RST_MID_PULSE;
			pulse_step[c] = RST_DEFAULT_STEP;
			in_place[c]   = 1'b0;
		end
	endfunction

	// Applies one request to the shadow state and returns the status word that
	// the block must produce for it.
	function automatic rsp_t slew_predict(input req_t rq);
		rsp_t        st;
		logic [15:0] delta;
		logic [15:0] shown_w [NCH_STORE];
		logic        shown_f [NCH_STORE];
		logic        taken;
		int unsigned c;
		st = '0;
		if (rq.req_type == REQ_TICK) begin
			// A tick that finds a channel on target only raises the flag; one
			// that lands it on target leaves the flag for the next tick.
			for (c = 0; c < NUM_CHANNELS; c++) begin
				if (pulse_now[c] == pulse_goal[c]) begin
					in_place[c] = 1'b1;
				end else begin
					delta = (pulse_now[c] < pulse_goal[c]) ?
						pulse_goal[c] - pulse_now[c] : pulse_now[c] - pulse_goal[c];
					if (delta > pulse_step[c])
						delta = pulse_step[c];
					if (pulse_now[c] < pulse_goal[c])
						pulse_now[c] = pulse_now[c] + delta;
					else
						pulse_now[c] = pulse_now[c] - delta;
				end
			end
		end else if (rq.channel < NUM_CHANNELS) begin
			c = rq.channel;
			if (rq.speed != 16'd0)
				pulse_step[c] = (rq.speed > lim_step) ? lim_step : rq.speed;
			// The range test comes first, so a code value inside the range is
			// taken as a plain width.
			taken = 1'b1;
			if (rq.target_value >= lim_min && rq.target_value <= lim_max)
				pulse_goal[c] = rq.target_value;
			else if (rq.target_value == CODE_MIN)
				pulse_goal[c] = lim_min;
			else if (rq.target_value == CODE_MAX)
				pulse_goal[c] = lim_max;
			else if (rq.target_value == CODE_MID)
				pulse_goal[c] = lim_mid;
			else
				taken = 1'b0;
			if (taken)
				in_place[c] = 1'b0;
			st.reply_value = pulse_now[c];
		end
		// Slots of channels that are not in use always read zero.
		for (c = 0; c < NCH_STORE; c++) begin
			shown_w[c] = (c < NUM_CHANNELS) ? pulse_now[c] : 16'd0;
			shown_f[c] = (c < NUM_CHANNELS) ? in_place[c] : 1'b0;
		end
		st.width_ch0  = shown_w[0];
		st.width_ch1  = shown_w[1];
		st.width_ch2  = shown_w[2];
		st.at_pos_ch0 = shown_f[0];
		st.at_pos_ch1 = shown_f[1];
		st.at_pos_ch2 = shown_f[2];
		return st;
	endfunction

	function automatic rsp_t status_word(input logic [15:0] reply, input logic [15:0] w0,
			input logic [15:0] w1, input logic [15:0] w2, input logic f0, input logic f1,
			input logic f2);
		rsp_t st;
		st.reply_value = reply;
		st.width_ch0   = w0;
		st.width_ch1   = w1;
		st.width_ch2   = w2;
		st.at_pos_ch0  = f0;
		st.at_pos_ch1  = f1;
		st.at_pos_ch2  = f2;
		return st;
	endfunction

	function automatic void add_row(input logic kind, input logic [1:0] ch,
			input logic [15:0] tv, input logic [15:0] sp, input bit typed, input rsp_t want);
		req_t rq;
		rq.req_type     = kind;
		rq.channel      = ch;
		rq.target_value = tv;
		rq.speed        = sp;
		plan_req.push_back(rq);
		plan_typed.push_back(typed);
		plan_want.push_back(want);
	endfunction

	// The directed rows assume the reset configuration: range 500..2500,
	// mid 1500, speed clamp 200 and a starting step of 20.
	function automatic void build_plan();
		rsp_t nil;
		nil = '0;
		// A set request to a channel that does not exist changes nothing.
		add_row(REQ_SET, BAD_CHANNEL, 16'd1000, 16'd5, 1'b1, nil);
		// A tick ignores its other fields; every channel heads for mid at step 20.
		add_row(REQ_TICK, 2'd3, 16'hFFFF, 16'hFFFF, 1'b1,
			status_word(16'd0, 16'd20, 16'd20, 16'd20, 1'b0, 1'b0, 1'b0));
		// Largest target in range, largest speed clamped down to 200.
		add_row(REQ_SET, 2'd0, 16'd2500, 16'hFFFF, 1'b1,
			status_word(16'd20, 16'd20, 16'd20, 16'd20, 1'b0, 1'b0, 1'b0));
		// Out-of-range codes: min for channel 1, max with step 1 for channel 2.
		add_row(REQ_SET, 2'd1, CODE_MIN, 16'd0, 1'b1,
			status_word(16'd20, 16'd20, 16'd20, 16'd20, 1'b0, 1'b0, 1'b0));
		add_row(REQ_SET, 2'd2, CODE_MAX, 16'd1, 1'b1,
			status_word(16'd20, 16'd20, 16'd20, 16'd20, 1'b0, 1'b0, 1'b0));
		add_row(REQ_TICK, 2'd0, 16'd0, 16'd0, 1'b1,
			status_word(16'd0, 16'd220, 16'd40, 16'd21, 1'b0, 1'b0, 1'b0));
		add_row(REQ_SET, 2'd2, CODE_MID, 16'd0, 1'b1,
			status_word(16'd21, 16'd220, 16'd40, 16'd21, 1'b0, 1'b0, 1'b0));
		// Just outside the range on both sides: ignored.
		add_row(REQ_SET, 2'd0, 16'd2501, 16'd0, 1'b0, nil);
		add_row(REQ_SET, 2'd0, 16'd499, 16'd0, 1'b0, nil);
		// Smallest target in range, speed exactly at the clamp.
		add_row(REQ_SET, 2'd1, 16'd500, 16'd200, 1'b0, nil);
		add_row(REQ_SET, 2'd0, 16'd620, 16'd200, 1'b0, nil);
		// Walk channels 0 and 1 onto their targets, then one more tick to
		// raise each flag.
		add_row(REQ_TICK, 2'd1, 16'h5555, 16'hAAAA, 1'b0, nil);
		add_row(REQ_TICK, 2'd2, 16'hAAAA, 16'h5555, 1'b0, nil);
		add_row(REQ_TICK, 2'd0, 16'd0, 16'd0, 1'b0, nil);
		add_row(REQ_TICK, 2'd0, 16'd0, 16'd0, 1'b0, nil);
		// Retaking the same target drops the flag until the next tick.
		add_row(REQ_SET, 2'd0, 16'd620, 16'd0, 1'b0, nil);
		add_row(REQ_TICK, 2'd0, 16'd0, 16'd0, 1'b0, nil);
		// An ignored target keeps the flag.
		add_row(REQ_SET, 2'd1, 16'hFFFF, 16'd0, 1'b0, nil);
		add_row(REQ_SET, 2'd2, 16'h5555, 16'hAAAA, 1'b0, nil);
		add_row(REQ_SET, BAD_CHANNEL, CODE_MAX, 16'd1, 1'b0, nil);
		add_row(REQ_TICK, 2'd0, 16'd0, 16'd0, 1'b0, nil);
	endfunction

	// Mostly back to back, some short gaps and a few long ones.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_target();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45 && lim_min <= lim_max)
			return 16'(lim_min + $urandom_range(0, lim_max - lim_min));
		if (r < 62) begin
			case ($urandom_range(0, 2))
				0: return CODE_MIN;
				1: return CODE_MAX;
				default: return CODE_MID;
			endcase
		end
		if (r < 72)
			return $urandom_range(0, 1) ? lim_min - 16'd1 : lim_max + 16'd1;
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic req_t random_request();
		req_t        rq;
		int unsigned r;
		rq.req_type     = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_SET;
		rq.channel      = ($urandom_range(0, 99) < 8) ? BAD_CHANNEL
			: 2'($urandom_range(0, NUM_CHANNELS - 1));
		rq.target_value = pick_target();
		r = $urandom_range(0, 99);
		if (r < 35)
			rq.speed = 16'd0;
		else if (r < 75)
			rq.speed = 16'($urandom_range(1, 300));
		else
			rq.speed = 16'($urandom_range(0, 65535));
		return rq;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatch_cnt < 50)
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// Offers one request after a random gap, holds it until the block takes
	// it, and then records the status word that it must produce.
	task automatic issue_request(input req_t rq, input bit typed, input rsp_t want);
		int unsigned gap;
		rsp_t        predicted;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= rq;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		// The predictor runs on typed rows too, so that its state stays in step.
		predicted = slew_predict(rq);
		pending_status.push_back(typed ? want : predicted);
	endtask

	// Always waits on the clock before it looks at the queue, so that a valid lowered just before
	// the call is never raised again in the same time step.
	task automatic wait_drained();
		@(posedge clk);
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MIN_PULSE:    lim_min   = value;
			REG_MAX_PULSE:    lim_max   = value;
			REG_MID_PULSE:    lim_mid   = value;
			REG_MAX_STEP:     lim_step  = value;
			REG_DEFAULT_STEP: dflt_step = value;
			default: ;
		endcase
	endtask

	task automatic write_setting(input logic [15:0] mn, input logic [15:0] mx,
			input logic [15:0] md, input logic [15:0] stp, input logic [15:0] dflt);
		write_reg(REG_MIN_PULSE, mn);
		write_reg(REG_MAX_PULSE, mx);
		write_reg(REG_MID_PULSE, md);
		write_reg(REG_MAX_STEP, stp);
		// The default step only matters at reset, so this write must not
		// change the behavior of any channel.
		write_reg(REG_DEFAULT_STEP, dflt);
	endtask

	// Phase 0 runs on the reset configuration. The others cover an empty
	// range with a zero speed clamp, the widest range with the largest clamp,
	// a range of the single width 0, a range of the single width 65535, a
	// random setting, and finally the reset values once more.
	task automatic apply_setting(input int unsigned phase);
		int unsigned lo;
		case (phase)
			1: write_setting(16'd3000, 16'd100, 16'd7, 16'd0, 16'hFFFF);
			2: write_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
			3: write_setting(16'd0, 16'd0, 16'd0, 16'd1, 16'd300);
			4: write_setting(16'hFFFF, 16'hFFFF, 16'h8000, 16'd300, 16'd7);
			5: begin
				lo = $urandom_range(0, 4000);
				write_setting(16'(lo), 16'(lo + $urandom_range(0, 4000)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(1, 1000)),
					16'($urandom_range(1, 65535)));
			end
			6: write_setting(RST_MIN_PULSE, RST_MAX_PULSE, RST_MID_PULSE, RST_MAX_STEP,
				RST_DEFAULT_STEP);
			default: ;
		endcase
	endtask

	// Result checker: every status word the block hands over is matched,
	// field by field, against the oldest one still owed.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_status.size() == 0) begin
				report_mismatch("status word with no request pending", 0, 0);
			end else begin
				want_status = pending_status.pop_front();
				if (rsp_data.reply_value != want_status.reply_value)
					report_mismatch("reply_value", rsp_data.reply_value,
						want_status.reply_value);
				if (rsp_data.width_ch0 != want_status.width_ch0)
					report_mismatch("width_ch0", rsp_data.width_ch0, want_status.width_ch0);
				if (rsp_data.width_ch1 != want_status.width_ch1)
					report_mismatch("width_ch1", rsp_data.width_ch1, want_status.width_ch1);
				if (rsp_data.width_ch2 != want_status.width_ch2)
					report_mismatch("width_ch2", rsp_data.width_ch2, want_status.width_ch2);
				if (rsp_data.at_pos_ch0 !== want_status.at_pos_ch0)
					report_mismatch("at_pos_ch0", rsp_data.at_pos_ch0, want_status.at_pos_ch0);
				if (rsp_data.at_pos_ch1 !== want_status.at_pos_ch1)
					report_mismatch("at_pos_ch1", rsp_data.at_pos_ch1, want_status.at_pos_ch1);
				if (rsp_data.at_pos_ch2 !== want_status.at_pos_ch2)
					report_mismatch("at_pos_ch2", rsp_data.at_pos_ch2, want_status.at_pos_ch2);
			end
		end
	end

	// Watchdog: a run that goes too long without moving a request or a status
	// word on either side is hung, and ends here as a failure.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: random stalls of mixed length, none at all while idling is
	// switched off, and once a long hold-off that backs the block up until it
	// stalls its request side.
	initial begin
		int unsigned len;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 99) < 25) begin
				len = pick_gap();
				if (len == 0)
					len = 1;
				rsp_stall <= 1'b1;
				repeat (len) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Sender and sequencing of the whole run.
	initial begin
		int unsigned n;
		int unsigned p;
		rsp_t        nil;
		nil          = '0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		req_valid    = 1'b0;
		req_data     = '0;
		idle_on      = 1'b1;
		hold_req     = 1'b0;
		tick_pct     = 50;
		mismatch_cnt = 0;
		quiet_cycles = 0;
		reset_shadow();
		build_plan();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < plan_req.size(); n++)
			issue_request(plan_req[n], plan_typed[n], plan_want[n]);

		for (p = 0; p < PHASES; p++) begin
			// Registers change only with the block empty.
			req_valid <= 1'b0;
			wait_drained();
			apply_setting(p);
			// Some phases lean harder on ticks so that channels settle and
			// their flags come up between target changes.
			tick_pct = $urandom_range(50, 80);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				// Receiver hold-off while the sender keeps offering requests.
				if (p == 1 && n == 60)
					hold_req = 1'b1;
				// Sender pause until every owed status word has arrived.
				if (p == 3 && n == 100) begin
					req_valid <= 1'b0;
					wait_drained();
				end
				issue_request(random_request(), 1'b0, nil);
			end
		end

		req_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
